// ===== sv/afskm_pkg.sv =====
// Shared types, constants and tables for the AFSK modulator with NRZI and bit stuffing.
// No dependencies; used by afskm_seq and afsk_nrzi_bitstuff_modulator.
`default_nettype none

package afskm_pkg;

	// Phase accumulator and sine table addressing
	localparam int PHASE_BITS      = 16;
	localparam int SINE_INDEX_BITS = 8;

	// Field widths
	localparam int STEP_W   = 15;
	localparam int SPB_W    = 6;
	localparam int RUN_W    = 3;
	localparam int LIMIT_W  = 20;
	localparam int USED_W   = 21;
	localparam int CNT_W    = 5;
	localparam int SAMPLE_W = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [SPB_W-1:0]    MAX_SPB    = 6'd32;
	localparam logic [RUN_W-1:0]    RUN_MAX    = 3'd7;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MID = 8'd127;

	// Register reset values
	localparam logic [STEP_W-1:0]  MARK_STEP_RST   = 15'd6554;
	localparam logic [STEP_W-1:0]  SPACE_STEP_RST  = 15'd12015;
	localparam logic [SPB_W-1:0]   SPB_RST         = 6'd10;
	localparam logic [RUN_W-1:0]   STUFF_RUN_RST   = 3'd5;
	localparam logic [LIMIT_W-1:0] SAMPLE_LIMIT_RST = 20'd1048575;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MARK_STEP    = 3'd0,
		REG_SPACE_STEP   = 3'd1,
		REG_SAMPLES_BIT  = 3'd2,
		REG_STUFF_RUN    = 3'd3,
		REG_SAMPLE_LIMIT = 3'd4
	} cfg_reg_t;

	// Words on the two data channels
	typedef struct packed {
		logic data_bit;
		logic stuff_allowed;
		logic frame_start;
	} bit_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic                tone_is_mark;
		logic                stuffed;
		logic                overflow;
		logic                last;
	} smp_item_t;

	// Datapath operations issued by the microcode
	typedef enum logic [2:0] {
		OP_ACCEPT,
		OP_NONE,
		OP_LOAD,
		OP_SAMPLE,
		OP_OVF,
		OP_AFTER
	} op_t;

	// Status flags returned from the datapath to the sequencer
	typedef struct packed {
		logic in_go;
		logic over;
		logic spb_zero;
		logic last_sample;
		logic stuff_next;
		logic hold;
	} seq_flags_t;

	// First quadrant of floor(127*sin), 65 points
	localparam logic [7:0] QUARTER_FLOOR [0:64] = '{
		8'd0,   8'd3,   8'd6,   8'd9,   8'd12,  8'd15,  8'd18,  8'd21,
		8'd24,  8'd27,  8'd30,  8'd33,  8'd36,  8'd39,  8'd42,  8'd45,
		8'd48,  8'd51,  8'd54,  8'd57,  8'd59,  8'd62,  8'd65,  8'd67,
		8'd70,  8'd73,  8'd75,  8'd78,  8'd80,  8'd82,  8'd85,  8'd87,
		8'd89,  8'd91,  8'd94,  8'd96,  8'd98,  8'd100, 8'd102, 8'd103,
		8'd105, 8'd107, 8'd108, 8'd110, 8'd112, 8'd113, 8'd114, 8'd116,
		8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd123, 8'd123,
		8'd124, 8'd125, 8'd125, 8'd126, 8'd126, 8'd126, 8'd126, 8'd126,
		8'd127
	};

	// Full-turn sine table entry: floor(127*(sin+1)), built from the quadrant
	function automatic logic [7:0] sine_value(input logic [7:0] k);
		logic [6:0] q;
		logic [6:0] m;
		logic [7:0] f;
		q = k[6:0];
		m = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
		f = QUARTER_FLOOR[m];
		if (!k[7])
			return 8'd127 + f;
		else if (m == 7'd0 || m == 7'd64)
			return 8'd127 - f;
		else
			return 8'd126 - f;
	endfunction

	// Top index bits of the phase, rescaled to the 256-entry table
	function automatic logic [7:0] sine_addr(input logic [PHASE_BITS-1:0] ph);
		logic [31:0] wide;
		wide = 32'(ph);
		if (PHASE_BITS >= SINE_INDEX_BITS)
			wide = wide >> (PHASE_BITS - SINE_INDEX_BITS);
		else
			wide = wide << (SINE_INDEX_BITS - PHASE_BITS);
		if (SINE_INDEX_BITS >= 8)
			wide = wide >> (SINE_INDEX_BITS - 8);
		else
			wide = wide << (8 - SINE_INDEX_BITS);
		return wide[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/afskm_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
// Depends on afskm_pkg (op_t, seq_flags_t).
`default_nettype none

module afskm_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire afskm_pkg::seq_flags_t flags,
	output afskm_pkg::op_t             op
);
	import afskm_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ZERO,
		ST_TONE,
		ST_OVF,
		ST_AFTER
	} step_t;

	typedef enum logic [2:0] {
		C_IN_GO,
		C_OVER,
		C_SPB_ZERO,
		C_LAST_SAMPLE,
		C_STUFF_NEXT,
		C_ALWAYS
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t jump;
		step_t fall;
	} ucode_t;

	step_t  step_q;
	step_t  step_next;
	ucode_t uw;
	logic   taken;

	// Control store: one word per step
	always_comb begin
		unique case (step_q)
			ST_IDLE:  uw = '{OP_ACCEPT, C_IN_GO,       ST_CHECK, ST_IDLE};
			ST_CHECK: uw = '{OP_NONE,   C_OVER,        ST_OVF,   ST_ZERO};
			ST_ZERO:  uw = '{OP_LOAD,   C_SPB_ZERO,    ST_AFTER, ST_TONE};
			ST_TONE:  uw = '{OP_SAMPLE, C_LAST_SAMPLE, ST_AFTER, ST_TONE};
			ST_OVF:   uw = '{OP_OVF,    C_ALWAYS,      ST_IDLE,  ST_IDLE};
			ST_AFTER: uw = '{OP_AFTER,  C_STUFF_NEXT,  ST_CHECK, ST_IDLE};
			default:  uw = '{OP_NONE,   C_ALWAYS,      ST_IDLE,  ST_IDLE};
		endcase
	end

	// Select the jump condition
	always_comb begin
		unique case (uw.cond)
			C_IN_GO:       taken = flags.in_go;
			C_OVER:        taken = flags.over;
			C_SPB_ZERO:    taken = flags.spb_zero;
			C_LAST_SAMPLE: taken = flags.last_sample;
			C_STUFF_NEXT:  taken = flags.stuff_next;
			C_ALWAYS:      taken = 1'b1;
			default:       taken = 1'b0;
		endcase
	end

	// Hold the step while the output word cannot be written
	always_comb begin
		if (flags.hold)
			step_next = step_q;
		else if (taken)
			step_next = uw.jump;
		else
			step_next = uw.fall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else begin
			step_q <= step_next;
		end
	end

	assign op = uw.op;

	// An overflow word always returns to the idle step
	a_ovf_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == ST_OVF && !flags.hold) |=> (step_q == ST_IDLE))
		else $error("overflow step did not return to idle");

	// A stalled emit step does not move
	a_hold_keeps_step: assert property (@(posedge clk) disable iff (!arst_n)
		flags.hold |=> $stable(step_q))
		else $error("step moved while held");

endmodule

`default_nettype wire

// ===== sv/afsk_nrzi_bitstuff_modulator.sv =====
// AFSK tone modulator with NRZI line coding and HDLC bit stuffing (top level, datapath).
// Depends on afskm_pkg and afskm_seq.
//
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  bit      | bit_valid/bit_stall  | bit_word: data_bit, stuff_allowed, frame_start
//  smp      | smp_valid/smp_stall  | smp_word: sample, tone_is_mark, stuffed, overflow, last
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (always ready)
//
// The sequencer emits one sample per cycle, while the output is not stalled, through the sine
// table into the output register, which sets the pace.
// Reset clears the sequencer, line state, counters and registers to their defaults.
// A stalled output word holds the sequencer on its emit step; bit_stall is high except in
// the accept step.
`default_nettype none

module afsk_nrzi_bitstuff_modulator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 bit_valid,
	output logic                                      bit_stall,
	input  wire afskm_pkg::bit_item_t                 bit_word,
	output logic                                      smp_valid,
	input  wire logic                                 smp_stall,
	output afskm_pkg::smp_item_t                      smp_word,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [afskm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [afskm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import afskm_pkg::*;

	// Configuration registers
	logic [STEP_W-1:0]  mark_step_q;
	logic [STEP_W-1:0]  space_step_q;
	logic [SPB_W-1:0]   spb_q;
	logic [RUN_W-1:0]   stuff_run_q;
	logic [LIMIT_W-1:0] limit_q;

	// Line and frame state
	logic [PHASE_BITS-1:0] phase_q;
	logic                  level_q;
	logic [RUN_W-1:0]      run_q;
	logic [USED_W-1:0]     used_q;
	logic                  ovf_q;
	logic                  stuffed_q;
	logic                  allowed_q;
	logic [CNT_W-1:0]      cnt_q;

	// Output register
	logic      out_valid_q;
	smp_item_t out_q;

	op_t        op;
	seq_flags_t flags;

	logic                  bit_fire;
	logic                  out_free;
	logic [SPB_W-1:0]      spb_eff;
	logic [USED_W-1:0]     used_sum;
	logic                  over;
	logic                  stuff_cond;
	logic                  last_sample;
	logic                  ovf_eff;
	logic                  level_eff;
	logic [RUN_W-1:0]      run_eff;
	logic [PHASE_BITS-1:0] step_ext;

	afskm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.op     (op)
	);

	assign cfg_ready = 1'b1;
	assign bit_stall = (op != OP_ACCEPT);
	assign bit_fire  = bit_valid && !bit_stall;
	assign out_free  = !out_valid_q || !smp_stall;

	// Clamp the tone length and test the frame budget
	assign spb_eff     = (spb_q > MAX_SPB) ? MAX_SPB : spb_q;
	assign used_sum    = used_q + USED_W'(spb_eff);
	assign over        = used_sum > USED_W'(limit_q);
	assign stuff_cond  = allowed_q && (run_q >= stuff_run_q);
	assign last_sample = ({1'b0, cnt_q} == (spb_eff - 6'd1));
	assign step_ext    = level_q ? PHASE_BITS'(mark_step_q) : PHASE_BITS'(space_step_q);

	// State as seen after a frame start clears it
	assign ovf_eff   = bit_word.frame_start ? 1'b0 : ovf_q;
	assign level_eff = bit_word.frame_start ? 1'b0 : level_q;
	assign run_eff   = bit_word.frame_start ? '0 : run_q;

	always_comb begin
		flags.in_go       = bit_fire && !ovf_eff;
		flags.over        = over;
		flags.spb_zero    = (spb_eff == '0);
		flags.last_sample = last_sample;
		flags.stuff_next  = !stuffed_q && stuff_cond;
		flags.hold        = (op == OP_SAMPLE || op == OP_OVF) && !out_free;
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_step_q  <= MARK_STEP_RST;
			space_step_q <= SPACE_STEP_RST;
			spb_q        <= SPB_RST;
			stuff_run_q  <= STUFF_RUN_RST;
			limit_q      <= SAMPLE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MARK_STEP:    mark_step_q  <= cfg_data[STEP_W-1:0];
				REG_SPACE_STEP:   space_step_q <= cfg_data[STEP_W-1:0];
				REG_SAMPLES_BIT:  spb_q        <= cfg_data[SPB_W-1:0];
				REG_STUFF_RUN:    stuff_run_q  <= cfg_data[RUN_W-1:0];
				REG_SAMPLE_LIMIT: limit_q      <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Datapath: act on the operation of the current microcode step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= '0;
			level_q   <= 1'b0;
			run_q     <= '0;
			used_q    <= '0;
			ovf_q     <= 1'b0;
			stuffed_q <= 1'b0;
			allowed_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			unique case (op)
				OP_ACCEPT: begin
					if (bit_fire) begin
						if (bit_word.frame_start) begin
							phase_q <= '0;
							used_q  <= '0;
							ovf_q   <= 1'b0;
						end
						// NRZI: a zero toggles the level and ends the ones run
						if (!ovf_eff) begin
							level_q   <= level_eff ^ !bit_word.data_bit;
							if (!bit_word.data_bit)
								run_q <= '0;
							else if (run_eff == RUN_MAX)
								run_q <= RUN_MAX;
							else
								run_q <= run_eff + 3'd1;
							stuffed_q <= 1'b0;
							allowed_q <= bit_word.stuff_allowed;
						end
					end
				end
				OP_NONE: ;
				OP_LOAD: begin
					cnt_q <= '0;
				end
				OP_SAMPLE: begin
					if (out_free) begin
						phase_q <= phase_q + step_ext;
						cnt_q   <= cnt_q + 5'd1;
						if (last_sample)
							used_q <= used_sum;
					end
				end
				OP_OVF: begin
					if (out_free)
						ovf_q <= 1'b1;
				end
				OP_AFTER: begin
					// Stuffed tone done, or leave the stuffing region: clear the run
					if (stuffed_q || !allowed_q) begin
						run_q <= '0;
					end else if (stuff_cond) begin
						level_q   <= !level_q;
						stuffed_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Output register: load a sample or the overflow word, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((op == OP_SAMPLE || op == OP_OVF) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!smp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_SAMPLE && out_free) begin
			out_q.sample       <= sine_value(sine_addr(phase_q));
			out_q.tone_is_mark <= level_q;
			out_q.stuffed      <= stuffed_q;
			out_q.overflow     <= 1'b0;
			out_q.last         <= last_sample && (stuffed_q || !stuff_cond);
		end else if (op == OP_OVF && out_free) begin
			out_q.sample       <= SAMPLE_MID;
			out_q.tone_is_mark <= level_q;
			out_q.stuffed      <= stuffed_q;
			out_q.overflow     <= 1'b1;
			out_q.last         <= 1'b1;
		end
	end

	assign smp_valid = out_valid_q;
	assign smp_word  = out_q;

	// An overflow word closes its bit and sits at the midpoint
	a_ovf_word: assert property (@(posedge clk) disable iff (!arst_n)
		(smp_valid && smp_word.overflow) |-> (smp_word.last && smp_word.sample == SAMPLE_MID))
		else $error("overflow word malformed");

	// Overflow stays set until a frame start is accepted
	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ovf_q && !(bit_fire && bit_word.frame_start)) |=> ovf_q)
		else $error("overflow cleared without frame start");

	// The sample counter stays inside the tone period
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SAMPLE) |-> ({1'b0, cnt_q} < spb_eff))
		else $error("sample counter beyond tone length");

	// Frame budget is only charged when it fits
	a_used_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SAMPLE && out_free && last_sample) |-> !over)
		else $error("tone emitted past the sample limit");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for afsk_nrzi_bitstuff_modulator: drives framed bits and register writes,
// predicts every tone sample in a shadow of the line coder and compares each output word.
// Depends on afskm_pkg and the modulator RTL only.
`timescale 1ns / 100ps

module testbench;
	import afskm_pkg::*;

	localparam int IDLE_LIMIT  = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = 100;
	localparam int PHASE_ITEMS = 32;
	localparam int MAX_LINES   = 40;

	// Shadow of the modulator: line state, registers and the queue of samples still due
	class afsk_tones;
		logic [STEP_W-1:0]     mark_step;
		logic [STEP_W-1:0]     space_step;
		logic [SPB_W-1:0]      bit_len;
		logic [RUN_W-1:0]      run_len;
		logic [LIMIT_W-1:0]    limit;
		logic [PHASE_BITS-1:0] phase;
		logic                  level;
		logic [RUN_W-1:0]      ones;
		logic [USED_W-1:0]     used;
		logic                  halted;
		logic [7:0]            sine_tab [256];
		smp_item_t             sample_q [$];
		int                    errors;

		function new();
			// floor(127*(sin+1)); the small offset keeps the exact peaks from rounding down
			for (int k = 0; k < 256; k++)
				sine_tab[k] = 8'($rtoi(127.0 * (1.0 + $sin(6.283185307179586 * k / 256.0))
					+ 1.0e-6));
			mark_step  = MARK_STEP_RST;
			space_step = SPACE_STEP_RST;
			bit_len    = SPB_RST;
			run_len    = STUFF_RUN_RST;
			limit      = SAMPLE_LIMIT_RST;
			errors     = 0;
			clear_line();
		endfunction

		function void clear_line();
			phase  = '0;
			level  = 1'b0;
			ones   = '0;
			used   = '0;
			halted = 1'b0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_MARK_STEP:    mark_step  = val[STEP_W-1:0];
				REG_SPACE_STEP:   space_step = val[STEP_W-1:0];
				REG_SAMPLES_BIT:  bit_len    = val[SPB_W-1:0];
				REG_STUFF_RUN:    run_len    = val[RUN_W-1:0];
				REG_SAMPLE_LIMIT: limit      = val[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		// One tone period, or the single overflow word when the frame budget runs out
		function bit play_tone(logic stuffed);
			int                n;
			logic [STEP_W-1:0] step;
			smp_item_t         w;
			n = (bit_len > MAX_SPB) ? int'(MAX_SPB) : int'(bit_len);
			step = level ? mark_step : space_step;
			w.tone_is_mark = level;
			w.stuffed      = stuffed;
			w.last         = 1'b0;
			if (int'(used) + n > int'(limit)) begin
				w.sample   = SAMPLE_MID;
				w.overflow = 1'b1;
				sample_q.push_back(w);
				halted = 1'b1;
				return 1'b0;
			end
			w.overflow = 1'b0;
			for (int i = 0; i < n; i++) begin
				w.sample = sine_tab[phase[PHASE_BITS-1 -: 8]];
				sample_q.push_back(w);
				phase = phase + {1'b0, step};
			end
			used = used + USED_W'(n);
			return 1'b1;
		endfunction

		// Advance the line coder by one accepted bit and queue the samples it causes
		function void note_bit(bit_item_t w);
			int        queued;
			smp_item_t t;
			if (w.frame_start)
				clear_line();
			if (halted)
				return;
			queued = sample_q.size();
			if (!w.data_bit) begin
				level = !level;
				ones  = '0;
			end else if (ones < RUN_MAX) begin
				ones = ones + 1'b1;
			end
			if (play_tone(1'b0)) begin
				if (w.stuff_allowed) begin
					if (ones >= run_len) begin
						level = !level;
						if (play_tone(1'b1))
							ones = '0;
					end
				end else begin
					ones = '0;
				end
			end
			// mark the final word of this bit
			if (sample_q.size() > queued) begin
				t = sample_q.pop_back();
				t.last = 1'b1;
				sample_q.push_back(t);
			end
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_LINES)
				$display("%0t ns mismatch: %s", $time, msg);
		endtask

		task check_sample(smp_item_t got);
			smp_item_t want;
			if (sample_q.size() == 0) begin
				report($sformatf("unexpected output word %h", got));
				return;
			end
			want = sample_q.pop_front();
			if (got.sample !== want.sample || got.tone_is_mark !== want.tone_is_mark ||
					got.stuffed !== want.stuffed || got.overflow !== want.overflow ||
					got.last !== want.last)
				report($sformatf({"sample %0d/%0d mark %b/%b stuffed %b/%b overflow %b/%b ",
					"last %b/%b (got/wanted)"}, got.sample, want.sample, got.tone_is_mark,
					want.tone_is_mark, got.stuffed, want.stuffed, got.overflow, want.overflow,
					got.last, want.last));
		endtask

		function int pending();
			return sample_q.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  bit_valid;
	logic                  bit_stall;
	bit_item_t             bit_word;
	logic                  smp_valid;
	logic                  smp_stall;
	smp_item_t             smp_word;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	afsk_tones tones;
	bit        quiet    = 1'b0;
	int        hold_req = 0;
	int        bits_sent = 0;
	int        idle_cycles = 0;

	afsk_nrzi_bitstuff_modulator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.bit_valid (bit_valid),
		.bit_stall (bit_stall),
		.bit_word  (bit_word),
		.smp_valid (smp_valid),
		.smp_stall (smp_stall),
		.smp_word  (smp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 0;
	end

	// Offer one bit word, idling first at random, and hold it until taken
	task automatic send_bit(input logic d, input logic a, input logic fs);
		bit_item_t w;
		w.data_bit      = d;
		w.stuff_allowed = a;
		w.frame_start   = fs;
		if (!quiet && $urandom_range(0, 99) < 20) begin
			bit_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		bit_valid <= 1'b1;
		bit_word  <= w;
		do @(posedge clk); while (bit_stall);
		tones.note_bit(w);
		bits_sent++;
	endtask

	task automatic send_byte(input logic [7:0] b, input logic a, input logic fs);
		for (int i = 0; i < 8; i++)
			send_bit(b[i], a, fs && i == 0);
	endtask

	// Flag, a few payload bytes inside the stuffing region, usually a closing flag
	task automatic send_frame();
		int n;
		n = $urandom_range(1, 4);
		send_byte(8'h7E, 1'b0, 1'b1);
		repeat (n)
			send_byte(($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom), 1'b1, 1'b0);
		if ($urandom_range(0, 9) != 0)
			send_byte(8'h7E, 1'b0, 1'b0);
	endtask

	// Drop valid and wait for every queued sample to arrive
	task automatic drain();
		bit_valid <= 1'b0;
		do @(posedge clk); while (tones.pending() != 0);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		tones.write_reg(idx, val);
	endtask

	// Let the block go idle, then load all five registers
	task automatic configure(input int mark, input int space, input int spb, input int run,
			input int lim);
		drain();
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_MARK_STEP, CFG_DATA_W'(mark));
		write_reg(REG_SPACE_STEP, CFG_DATA_W'(space));
		write_reg(REG_SAMPLES_BIT, CFG_DATA_W'(spb));
		write_reg(REG_STUFF_RUN, CFG_DATA_W'(run));
		write_reg(REG_SAMPLE_LIMIT, CFG_DATA_W'(lim));
		cfg_valid <= 1'b0;
	endtask

	// Sample sink: check taken words, stall at random or for a long hold-off on request
	initial begin : sample_sink
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		smp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && smp_valid && !smp_stall)
				tones.check_sample(smp_word);
			if (hold_left > 0)
				hold_left--;
			else if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			smp_stall <= (hold_left > 0) || (!quiet && $urandom_range(0, 99) < 20);
		end
	end

	// Watchdog: end the run when nothing moves on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (bit_valid && !bit_stall) || (smp_valid && !smp_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		int  goal;
		bit  paused;
		tones = new();
		arst_n    <= 1'b0;
		bit_valid <= 1'b0;
		bit_word  <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MARK_STEP;
		cfg_data  <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);

		// long ones run with stuffing, zero bits, a bit outside the stuffing region
		configure(6554, 12015, 10, 5, 1048575);
		send_bit(1'b0, 1'b0, 1'b1);
		repeat (8)
			send_bit(1'b1, 1'b1, 1'b0);
		send_bit(1'b0, 1'b1, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);

		// oversized bit length, zero stuff run, extreme steps
		configure(32767, 1, 40, 0, 1048575);
		send_bit(1'b1, 1'b1, 1'b1);
		send_bit(1'b0, 1'b1, 1'b0);
		send_bit(1'b1, 1'b0, 1'b0);

		// empty tone periods with zero steps and a zero budget: no words at all
		configure(0, 0, 0, 7, 0);
		send_bit(1'b1, 1'b1, 1'b1);
		send_bit(1'b0, 1'b1, 1'b0);

		// budget runs out, bits dropped while overflowed, a new frame recovers
		configure(1000, 2000, 10, 7, 25);
		send_bit(1'b1, 1'b1, 1'b1);
		send_bit(1'b1, 1'b1, 1'b0);
		send_bit(1'b1, 1'b1, 1'b0);
		send_bit(1'b0, 1'b0, 1'b0);
		send_bit(1'b1, 1'b1, 1'b0);
		send_bit(1'b1, 1'b1, 1'b1);

		// stuffed tone refused for lack of budget
		configure(1000, 2000, 10, 1, 15);
		send_bit(1'b1, 1'b1, 1'b1);
		send_bit(1'b0, 1'b1, 1'b1);

		// random frames under a series of register settings
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: configure(6554, 12015, 10, 5, 1048575);
				1: configure($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(1, 8), $urandom_range(0, 7), 1048575);
				2: configure(32767, 1, 32, 7, 1048575);
				3: configure(0, 32767, 63, $urandom_range(0, 7), 1048575);
				4: configure($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(1, 4), $urandom_range(0, 7), $urandom_range(20, 120));
				5: configure($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(1, 63), $urandom_range(0, 7),
					($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000)
						: $urandom_range(0, 1048575));
				default: configure($urandom_range(0, 32767), $urandom_range(0, 32767),
					$urandom_range(1, 16), $urandom_range(0, 7), $urandom_range(100, 600));
			endcase
			// first setting: no idling, and a long receiver hold-off to back the block up
			quiet = (p == 0);
			if (p == 0)
				hold_req <= hold_req + 1;
			goal = bits_sent + PHASE_ITEMS;
			paused = 1'b0;
			while (bits_sent < goal) begin
				if (p == 1 && !paused && bits_sent >= goal - PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
				if ($urandom_range(0, 99) < 15)
					repeat ($urandom_range(1, 6))
						send_bit(1'($urandom), 1'($urandom), $urandom_range(0, 3) == 0);
				else
					send_frame();
			end
			quiet = 1'b0;
		end

		drain();
		repeat (SETTLE) @(posedge clk);
		if (tones.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/afskm_pkg.sv
sv/afskm_seq.sv
sv/afsk_nrzi_bitstuff_modulator.sv
tb/testbench.sv
